// File: rtl/core/s5af_pkg.sv
// Shared types, codes and constants for the SOCKS5 address field parser.
// No dependencies; every other file in rtl/core uses this package.
package s5af_pkg;

    // Depth of the result queue between the parser front and the output side.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Address type bytes as they appear on the wire.
    localparam logic [7:0] ATYP_IPV4   = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN = 8'h03;
    localparam logic [7:0] ATYP_IPV6   = 8'h04;

    localparam logic [7:0] IPV4_LEN = 8'd4;
    localparam logic [7:0] IPV6_LEN = 8'd16;

    typedef enum logic [1:0] {
        KIND_IPV4   = 2'd0,
        KIND_DOMAIN = 2'd1,
        KIND_IPV6   = 2'd2
    } addr_kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_TYPE     = 3'd1,
        ST_EMPTY_DOMAIN = 3'd2,
        ST_SHORT_IPV4   = 3'd3,
        ST_SHORT_IPV6   = 3'd4,
        ST_NO_LENGTH    = 3'd5,
        ST_SHORT_DOMAIN = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_DLEN    = 3'd1,
        PH_ADDR    = 3'd2,
        PH_PORT_HI = 3'd3,
        PH_PORT_LO = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    localparam logic RK_ADDR_BYTE = 1'b0;
    localparam logic RK_STATUS    = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  host_byte;
        logic [7:0]  byte_index;
        logic [1:0]  address_type;
        logic [15:0] port_number;
        logic [8:0]  consumed_count;
        logic [2:0]  status;
        logic        last_result;
    } out_item_t;

    // Status reported when the buffer ends inside an address.
    function automatic status_t short_code(input addr_kind_t kind);
        status_t code;
        case (kind)
            KIND_IPV4: code = ST_SHORT_IPV4;
            KIND_IPV6: code = ST_SHORT_IPV6;
            default:   code = ST_SHORT_DOMAIN;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/core/s5af_front.sv
// Parser front: takes one byte per transfer, tracks the field phase and
// produces zero or one result item per byte. Depends on s5af_pkg.
module s5af_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  s5af_pkg::in_item_t  item,
    output logic                res_valid,
    output s5af_pkg::out_item_t res
);

    s5af_pkg::phase_t     phase_reg, phase_next;
    s5af_pkg::addr_kind_t kind_reg, kind_next;
    logic [7:0]           left_reg, left_next;
    logic [7:0]           hpos_reg, hpos_next;
    logic [7:0]           port_hi_reg, port_hi_next;
    logic [8:0]           used_reg, used_next;

    // Decoded event for the current byte.
    logic                 emit_status;
    logic                 emit_byte;
    s5af_pkg::status_t    code;
    s5af_pkg::addr_kind_t kind_eff;
    logic [7:0]           left_dec;
    logic [8:0]           used_inc;
    logic                 eob;
    logic [7:0]           b;

    assign eob      = item.end_of_buffer;
    assign b        = item.in_byte;
    assign left_dec = left_reg - 8'd1;
    // A type byte starts a fresh count.
    assign used_inc = (phase_reg == s5af_pkg::PH_TYPE) ? 9'd1 : used_reg + 9'd1;

    always_comb
    begin
        emit_status = 1'b0;
        emit_byte   = 1'b0;
        code        = s5af_pkg::ST_OK;
        kind_eff    = kind_reg;
        if (accept)
        begin
            case (phase_reg)
                s5af_pkg::PH_TYPE:
                begin
                    case (b)
                        s5af_pkg::ATYP_IPV4:
                        begin
                            kind_eff    = s5af_pkg::KIND_IPV4;
                            emit_status = eob;
                            code        = s5af_pkg::ST_SHORT_IPV4;
                        end
                        s5af_pkg::ATYP_IPV6:
                        begin
                            kind_eff    = s5af_pkg::KIND_IPV6;
                            emit_status = eob;
                            code        = s5af_pkg::ST_SHORT_IPV6;
                        end
                        s5af_pkg::ATYP_DOMAIN:
                        begin
                            kind_eff    = s5af_pkg::KIND_DOMAIN;
                            emit_status = eob;
                            code        = s5af_pkg::ST_NO_LENGTH;
                        end
                        default:
                        begin
                            kind_eff    = s5af_pkg::KIND_IPV4;
                            emit_status = 1'b1;
                            code        = s5af_pkg::ST_BAD_TYPE;
                        end
                    endcase
                end
                s5af_pkg::PH_DLEN:
                begin
                    // An empty domain wins over a buffer that ends here.
                    if (b == 8'd0)
                    begin
                        emit_status = 1'b1;
                        code        = s5af_pkg::ST_EMPTY_DOMAIN;
                    end
                    else if (eob)
                    begin
                        emit_status = 1'b1;
                        code        = s5af_pkg::ST_SHORT_DOMAIN;
                    end
                end
                s5af_pkg::PH_ADDR:
                begin
                    emit_status = eob;
                    emit_byte   = !eob;
                    code        = s5af_pkg::short_code(kind_reg);
                end
                s5af_pkg::PH_PORT_HI:
                begin
                    emit_status = eob;
                    code        = s5af_pkg::short_code(kind_reg);
                end
                s5af_pkg::PH_PORT_LO:
                begin
                    emit_status = 1'b1;
                    code        = s5af_pkg::ST_OK;
                end
                default:
                begin
                    emit_status = 1'b0;
                end
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        left_next    = left_reg;
        hpos_next    = hpos_reg;
        port_hi_next = port_hi_reg;
        used_next    = used_reg;
        if (accept)
        begin
            if (phase_reg == s5af_pkg::PH_DONE)
            begin
                if (eob)
                begin
                    phase_next = s5af_pkg::PH_TYPE;
                end
            end
            else
            begin
                used_next = used_inc;
                kind_next = kind_eff;
                case (phase_reg)
                    s5af_pkg::PH_TYPE:
                    begin
                        hpos_next    = 8'd0;
                        port_hi_next = 8'd0;
                        left_next    = 8'd0;
                        case (b)
                            s5af_pkg::ATYP_IPV4:
                            begin
                                left_next  = s5af_pkg::IPV4_LEN;
                                phase_next = s5af_pkg::PH_ADDR;
                            end
                            s5af_pkg::ATYP_IPV6:
                            begin
                                left_next  = s5af_pkg::IPV6_LEN;
                                phase_next = s5af_pkg::PH_ADDR;
                            end
                            s5af_pkg::ATYP_DOMAIN:
                            begin
                                phase_next = s5af_pkg::PH_DLEN;
                            end
                            default:
                            begin
                                phase_next = s5af_pkg::PH_TYPE;
                            end
                        endcase
                    end
                    s5af_pkg::PH_DLEN:
                    begin
                        left_next  = b;
                        phase_next = s5af_pkg::PH_ADDR;
                    end
                    s5af_pkg::PH_ADDR:
                    begin
                        hpos_next = hpos_reg + 8'd1;
                        left_next = left_dec;
                        if (left_dec == 8'd0)
                        begin
                            phase_next = s5af_pkg::PH_PORT_HI;
                        end
                    end
                    s5af_pkg::PH_PORT_HI:
                    begin
                        port_hi_next = b;
                        phase_next   = s5af_pkg::PH_PORT_LO;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
                // A status item closes the field; its own end byte re-arms at once.
                if (emit_status)
                begin
                    phase_next = eob ? s5af_pkg::PH_TYPE : s5af_pkg::PH_DONE;
                end
            end
        end
    end

    // Result item.
    always_comb
    begin
        res       = '0;
        res_valid = emit_status || emit_byte;
        if (emit_byte)
        begin
            res.result_kind  = s5af_pkg::RK_ADDR_BYTE;
            res.host_byte    = b;
            res.byte_index   = hpos_reg;
            res.address_type = kind_reg;
        end
        else if (emit_status)
        begin
            res.result_kind  = s5af_pkg::RK_STATUS;
            res.address_type = kind_eff;
            res.status       = code;
            res.last_result  = 1'b1;
            if (code == s5af_pkg::ST_OK)
            begin
                res.port_number    = {port_hi_reg, b};
                res.consumed_count = used_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= s5af_pkg::PH_TYPE;
            kind_reg    <= s5af_pkg::KIND_IPV4;
            left_reg    <= 8'd0;
            hpos_reg    <= 8'd0;
            port_hi_reg <= 8'd0;
            used_reg    <= 9'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            left_reg    <= left_next;
            hpos_reg    <= hpos_next;
            port_hi_reg <= port_hi_next;
            used_reg    <= used_next;
        end
    end

    a_done_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eob && phase_reg == s5af_pkg::PH_DONE) |=> phase_reg == s5af_pkg::PH_TYPE)
        else $error("parser did not re-arm on end of buffer");

    a_byte_only_in_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.result_kind == s5af_pkg::RK_ADDR_BYTE)
            |-> (phase_reg == s5af_pkg::PH_ADDR && left_reg != 8'd0))
        else $error("address byte emitted outside the address phase");

endmodule

// File: rtl/core/s5af_queue.sv
// Result queue and output side: holds parsed result items until the consumer
// takes them, so front and back stall independently. Depends on s5af_pkg.
module s5af_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  s5af_pkg::out_item_t wr_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output s5af_pkg::out_item_t rd_data
);

    s5af_pkg::out_item_t                mem [s5af_pkg::QDEPTH];
    logic [s5af_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [s5af_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [s5af_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                               rd_en;

    assign full    = (count_reg == s5af_pkg::QCNT_W'(s5af_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_en   = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("write into a full result queue");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == s5af_pkg::QCNT_W'(s5af_pkg::QDEPTH))
            == (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with the fill count");

endmodule

// File: rtl/core/socks5_address_field_parser_core.sv
// Top level of the SOCKS5 address field parser: parser front feeding a
// result queue. Depends on s5af_pkg, s5af_front and s5af_queue.
//
//  channel   handshake          payload               transfer when
//  request   push / full        s5af_pkg::in_item_t   push && !full
//  result    pop / empty        s5af_pkg::out_item_t  pop && !empty
//
// One byte is taken per cycle while full is low; the parser phase updates in the same cycle.
// A result is written into the result queue as its byte is taken and waits there until popped.
// full rises only when the four-entry result queue is full.
// Reset (rst_n low) returns the parser to expecting a type byte and empties the queue.
module socks5_address_field_parser_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  s5af_pkg::in_item_t  request,
    input  logic                pop,
    output logic                empty,
    output s5af_pkg::out_item_t result
);

    logic                accept;
    logic                res_valid;
    s5af_pkg::out_item_t res;

    assign accept = push && !full;

    s5af_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (request),
        .res_valid (res_valid),
        .res       (res)
    );

    s5af_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .rd_data (result)
    );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for socks5_address_field_parser_core: drives address
// fields byte by byte and checks every result against a built-in parser model.
// Depends on s5af_pkg and the core; stands alone otherwise.
module testbench;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DRAIN_CYCLES = 12;

    // Tracks the parser state and holds the results still owed by the core.
    class address_scoreboard;
        s5af_pkg::out_item_t  owed_q[$];
        int                   errors;
        s5af_pkg::phase_t     phase;
        s5af_pkg::addr_kind_t kind;
        logic [7:0]           left;
        logic [7:0]           pos;
        logic [7:0]           port_hi;
        logic [8:0]           used;

        function new();
            errors  = 0;
            phase   = s5af_pkg::PH_TYPE;
            kind    = s5af_pkg::KIND_IPV4;
            left    = '0;
            pos     = '0;
            port_hi = '0;
            used    = '0;
        endfunction

        function s5af_pkg::status_t gap_status();
            if (kind == s5af_pkg::KIND_IPV4)
                return s5af_pkg::ST_SHORT_IPV4;
            if (kind == s5af_pkg::KIND_IPV6)
                return s5af_pkg::ST_SHORT_IPV6;
            return s5af_pkg::ST_SHORT_DOMAIN;
        endfunction

        function void note_byte(s5af_pkg::in_item_t req);
            s5af_pkg::out_item_t item;
            logic [7:0]          b;
            logic                eob;
            logic                report;
            s5af_pkg::status_t   code;
            logic [15:0]         port;
            logic [8:0]          used_now;
            b        = req.in_byte;
            eob      = req.end_of_buffer;
            report   = 1'b0;
            code     = s5af_pkg::ST_OK;
            port     = '0;
            used_now = '0;
            if (phase == s5af_pkg::PH_DONE)
            begin
                if (eob)
                    phase = s5af_pkg::PH_TYPE;
                return;
            end
            if (phase == s5af_pkg::PH_TYPE)
            begin
                used    = '0;
                pos     = '0;
                left    = '0;
                port_hi = '0;
                kind    = s5af_pkg::KIND_IPV4;
            end
            used = used + 9'd1;
            case (phase)
                s5af_pkg::PH_TYPE:
                begin
                    if (b == s5af_pkg::ATYP_IPV4 || b == s5af_pkg::ATYP_IPV6)
                    begin
                        kind  = (b == s5af_pkg::ATYP_IPV4) ? s5af_pkg::KIND_IPV4
                                                           : s5af_pkg::KIND_IPV6;
                        left  = (b == s5af_pkg::ATYP_IPV4) ? s5af_pkg::IPV4_LEN
                                                           : s5af_pkg::IPV6_LEN;
                        phase = s5af_pkg::PH_ADDR;
                        if (eob)
                        begin
                            report = 1'b1;
                            code   = gap_status();
                        end
                    end
                    else if (b == s5af_pkg::ATYP_DOMAIN)
                    begin
                        kind  = s5af_pkg::KIND_DOMAIN;
                        phase = s5af_pkg::PH_DLEN;
                        if (eob)
                        begin
                            report = 1'b1;
                            code   = s5af_pkg::ST_NO_LENGTH;
                        end
                    end
                    else
                    begin
                        kind   = s5af_pkg::KIND_IPV4;
                        report = 1'b1;
                        code   = s5af_pkg::ST_BAD_TYPE;
                    end
                end
                s5af_pkg::PH_DLEN:
                begin
                    if (b == 8'd0)
                    begin
                        report = 1'b1;
                        code   = s5af_pkg::ST_EMPTY_DOMAIN;
                    end
                    else if (eob)
                    begin
                        report = 1'b1;
                        code   = s5af_pkg::ST_SHORT_DOMAIN;
                    end
                    else
                    begin
                        left  = b;
                        phase = s5af_pkg::PH_ADDR;
                    end
                end
                s5af_pkg::PH_ADDR:
                begin
                    if (eob)
                    begin
                        report = 1'b1;
                        code   = gap_status();
                    end
                    else
                    begin
                        item              = '0;
                        item.result_kind  = s5af_pkg::RK_ADDR_BYTE;
                        item.host_byte    = b;
                        item.byte_index   = pos;
                        item.address_type = kind;
                        owed_q.push_back(item);
                        pos  = pos + 8'd1;
                        left = left - 8'd1;
                        if (left == 8'd0)
                            phase = s5af_pkg::PH_PORT_HI;
                    end
                end
                s5af_pkg::PH_PORT_HI:
                begin
                    if (eob)
                    begin
                        report = 1'b1;
                        code   = gap_status();
                    end
                    else
                    begin
                        port_hi = b;
                        phase   = s5af_pkg::PH_PORT_LO;
                    end
                end
                s5af_pkg::PH_PORT_LO:
                begin
                    report   = 1'b1;
                    code     = s5af_pkg::ST_OK;
                    port     = {port_hi, b};
                    used_now = used;
                end
                default:
                    phase = eob ? s5af_pkg::PH_TYPE : s5af_pkg::PH_DONE;
            endcase
            if (report)
            begin
                item                = '0;
                item.result_kind    = s5af_pkg::RK_STATUS;
                item.address_type   = kind;
                item.port_number    = port;
                item.consumed_count = used_now;
                item.status         = code;
                item.last_result    = 1'b1;
                owed_q.push_back(item);
                // A status byte that also ends the buffer re-arms the parser at once.
                phase = eob ? s5af_pkg::PH_TYPE : s5af_pkg::PH_DONE;
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(s5af_pkg::out_item_t got);
            s5af_pkg::out_item_t want;
            if (owed_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, expected none actual %h",
                         $time, got);
                return;
            end
            want = owed_q.pop_front();
            compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
            compare_field("host_byte", 16'(want.host_byte), 16'(got.host_byte));
            compare_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
            compare_field("address_type", 16'(want.address_type), 16'(got.address_type));
            compare_field("port_number", want.port_number, got.port_number);
            compare_field("consumed_count", 16'(want.consumed_count),
                          16'(got.consumed_count));
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("last_result", 16'(want.last_result), 16'(got.last_result));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                push    = 1'b0;
    logic                pop     = 1'b0;
    s5af_pkg::in_item_t  request = '0;
    logic                full;
    logic                empty;
    s5af_pkg::out_item_t result;

    address_scoreboard sb = new();
    bit                steady = 1'b0;
    int                idle_cycles = 0;
    int                pop_hold = 0;

    socks5_address_field_parser_core i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly no gap, else mostly short ones and now and then a long one; none during a steady stretch.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_byte(request);
            if (pop && !empty)
                sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                pop_hold = idle_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("FAIL socks5_address_field_parser_core");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        request <= '{in_byte: b, end_of_buffer: eob};
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Only the last byte of a buffer carries end_of_buffer, which always re-arms the parser.
    task automatic send_buffer(input logic [7:0] bytes_q[$]);
        for (int i = 0; i < bytes_q.size(); i++)
            send_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    initial
    begin
        logic [7:0] buf_q[$];
        int         counted;
        int         sel;
        int         kind_sel;
        int         dlen;
        int         r;
        int         cut;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_buffer('{s5af_pkg::ATYP_IPV4, 8'hff, 8'h00, 8'h80, 8'h7f, 8'hff, 8'hff});
        send_buffer('{8'h00});
        send_buffer('{8'hff, s5af_pkg::ATYP_IPV4, 8'h55});
        send_buffer('{s5af_pkg::ATYP_DOMAIN, 8'h00});
        send_buffer('{s5af_pkg::ATYP_DOMAIN, 8'h00, 8'h12});
        send_buffer('{s5af_pkg::ATYP_DOMAIN});
        send_buffer('{s5af_pkg::ATYP_DOMAIN, 8'h05});
        send_buffer('{s5af_pkg::ATYP_IPV4});
        send_buffer('{s5af_pkg::ATYP_IPV6, 8'haa, 8'hbb});
        send_buffer('{s5af_pkg::ATYP_IPV4, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00});

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 15)
                steady = ~steady;
            buf_q.delete();
            sel = $urandom_range(0, 99);
            if (sel < 80)
            begin
                kind_sel = $urandom_range(0, 2);
                if (kind_sel == 0)
                begin
                    buf_q.push_back(s5af_pkg::ATYP_IPV4);
                    dlen = int'(s5af_pkg::IPV4_LEN);
                end
                else if (kind_sel == 1)
                begin
                    buf_q.push_back(s5af_pkg::ATYP_IPV6);
                    dlen = int'(s5af_pkg::IPV6_LEN);
                end
                else
                begin
                    // Mostly short names, a few long ones and the longest.
                    r = $urandom_range(0, 19);
                    if (r < 16)
                        dlen = $urandom_range(1, 16);
                    else if (r < 19)
                        dlen = $urandom_range(17, 254);
                    else
                        dlen = 255;
                    buf_q.push_back(s5af_pkg::ATYP_DOMAIN);
                    buf_q.push_back(8'(dlen));
                end
                repeat (dlen + 2)
                    buf_q.push_back(8'($urandom_range(0, 255)));
                if (sel < 65)
                begin
                    counted += buf_q.size();
                    if ($urandom_range(0, 1) == 1)
                        repeat ($urandom_range(1, 4))
                            buf_q.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    cut = $urandom_range(0, buf_q.size() - 1);
                    while (buf_q.size() > cut + 1)
                        void'(buf_q.pop_back());
                    counted += buf_q.size();
                end
            end
            else if (sel < 88)
            begin
                buf_q.push_back(s5af_pkg::ATYP_DOMAIN);
                buf_q.push_back(8'h00);
                counted += 2;
                if ($urandom_range(0, 1) == 1)
                    repeat ($urandom_range(1, 3))
                        buf_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    buf_q.push_back(8'($urandom_range(0, 255)));
                counted += buf_q.size();
            end
            send_buffer(buf_q);
        end
        push <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        // Anything still waiting in the core at this point was never owed.
        if (!empty)
        begin
            sb.errors++;
            $display("%0t: result with none expected, expected none actual %h",
                     $time, result);
        end
        if (sb.errors == 0)
            $display("PASS socks5_address_field_parser_core");
        else
            $display("FAIL socks5_address_field_parser_core");
        $finish;
    end

endmodule
